// File: rtl/core/hbt_pkg.sv
// Package: shared constants, payload structs and controller/datapath interface types.
package hbt_pkg;

   localparam int ENTRIES   = 16;
   localparam int APPS      = 16;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int APP_W     = 4;
   localparam int MAX_RES   = 16;
   localparam int RES_W     = $clog2(MAX_RES + 1);

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] PERIOD_RESET  = 16'd250;

   typedef enum logic [2:0] {
      KIND_TICK   = 3'd0,
      KIND_PING   = 3'd1,
      KIND_PONG   = 3'd2,
      KIND_PANG   = 3'd3,
      KIND_FINISH = 3'd4
   } kind_type;

   localparam logic [1:0] EV_INACTIVE = 2'd0;
   localparam logic [1:0] EV_ACTIVE   = 2'd1;
   localparam logic [1:0] EV_DROPPED  = 2'd2;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_PERIOD  = 1'b1;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] method_id;
      logic [3:0]  app_id;
      logic [31:0] serial;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [15:0] method_id_out;
      logic [3:0]  app_id_out;
      logic [31:0] elapsed_ms;
      logic        last;
   } rsp_type;

   // What the datapath should do in a given cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,       // capture request, tick clock
      OP_PROBE,      // evaluate entry at index
      OP_SHIFT,      // move entry idx+1 to idx
      OP_SET_STAMP,  // refresh stamp of entry idx
      OP_APPEND,     // write request at entry_count
      OP_MARK,       // mark app of entry idx asleep
      OP_WAKE,       // clear asleep of request app
      OP_DEC,        // entry_count - 1
      OP_STOP        // stop the scan timer
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [IDX_W-1:0] idx;
      logic            start_timer;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             scan_due;   // after a tick, a scan is due
      logic             match_pong;
      logic             match_pang;
      logic             app_match;
      logic             old_awake;  // entry old and app awake
      logic             req_asleep; // request app asleep
      logic             req_app_ok;
   } sts_type;

endpackage

// File: rtl/core/hbt_datapath.sv
// Datapath: entry table, sleep table, ms clock, scan timer and result formation.
module hbt_datapath
   import hbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  req_type     req_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output rsp_type     res_ev
);

   logic [15:0] timeout_ff, period_ff;
   logic [15:0] e_method_ff [ENTRIES];
   logic [3:0]  e_app_ff    [ENTRIES];
   logic [31:0] e_serial_ff [ENTRIES];
   logic [31:0] e_stamp_ff  [ENTRIES];
   logic [CNT_W-1:0] count_ff;
   logic [APPS-1:0]  asleep_ff;
   logic [31:0] asleep_stamp_ff [APPS];
   logic [31:0] now_ff;
   logic        running_ff;
   logic [15:0] phase_ff;
   logic        due_ff;
   req_type     req_ff;

   logic [IDX_W-1:0] nxt;
   logic [31:0] age;
   logic [15:0] period;
   logic [15:0] phase_inc;

   assign nxt = cmd.idx + IDX_W'(1);
   assign age = now_ff - e_stamp_ff[cmd.idx];
   assign period = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign phase_inc = phase_ff + 16'd1;

   // Status toward the controller.
   always_comb begin
      sts.count      = count_ff;
      sts.scan_due   = due_ff;
      sts.app_match  = e_app_ff[cmd.idx] == req_ff.app_id;
      sts.match_pong = sts.app_match && e_method_ff[cmd.idx] == req_ff.method_id
                       && e_serial_ff[cmd.idx] == req_ff.serial;
      sts.match_pang = sts.app_match && e_method_ff[cmd.idx] == req_ff.method_id
                       && e_serial_ff[cmd.idx] == 32'd0;
      sts.old_awake  = (age > {16'd0, timeout_ff}) && !asleep_ff[e_app_ff[cmd.idx]];
      sts.req_asleep = asleep_ff[req_ff.app_id];
      sts.req_app_ok = 1'b1;
   end

   // Result beat contents for the current command.
   always_comb begin
      res_ev = '0;
      unique case (cmd.op)
         OP_MARK: begin
            res_ev.event_res     = EV_INACTIVE;
            res_ev.method_id_out = e_method_ff[cmd.idx];
            res_ev.app_id_out    = e_app_ff[cmd.idx];
            res_ev.elapsed_ms    = age;
         end
         OP_WAKE: begin
            res_ev.event_res     = EV_ACTIVE;
            res_ev.method_id_out = req_ff.method_id;
            res_ev.app_id_out    = req_ff.app_id;
            res_ev.elapsed_ms    = now_ff - asleep_stamp_ff[req_ff.app_id];
         end
         default: begin
            res_ev.event_res     = EV_DROPPED;
            res_ev.method_id_out = req_ff.method_id;
            res_ev.app_id_out    = req_ff.app_id;
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         period_ff  <= PERIOD_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_TIMEOUT) timeout_ff <= csr_data;
         else                          period_ff  <= csr_data;
      end
   end

   // Control state of the table and timer.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         asleep_ff  <= '0;
         now_ff     <= '0;
         running_ff <= 1'b0;
         phase_ff   <= '0;
         due_ff     <= 1'b0;
      end else begin
         if (cmd.start_timer && !running_ff) begin
            running_ff <= 1'b1;
            phase_ff   <= '0;
         end
         unique case (cmd.op)
            OP_LOAD: begin
               due_ff <= 1'b0;
               if (req_data.kind == KIND_TICK) begin
                  now_ff <= now_ff + 32'd1;
                  if (running_ff) begin
                     if (phase_inc >= period) begin
                        phase_ff <= '0;
                        due_ff   <= 1'b1;
                     end else begin
                        phase_ff <= phase_inc;
                     end
                  end
               end
            end
            OP_APPEND: count_ff <= count_ff + CNT_W'(1);
            OP_DEC:    count_ff <= count_ff - CNT_W'(1);
            OP_MARK:   asleep_ff[e_app_ff[cmd.idx]] <= 1'b1;
            OP_WAKE:   asleep_ff[req_ff.app_id] <= 1'b0;
            OP_STOP:   running_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD:      req_ff <= req_data;
         OP_SHIFT: begin
            e_method_ff[cmd.idx] <= e_method_ff[nxt];
            e_app_ff[cmd.idx]    <= e_app_ff[nxt];
            e_serial_ff[cmd.idx] <= e_serial_ff[nxt];
            e_stamp_ff[cmd.idx]  <= e_stamp_ff[nxt];
         end
         OP_SET_STAMP: e_stamp_ff[cmd.idx] <= now_ff;
         OP_APPEND: begin
            e_method_ff[cmd.idx] <= req_ff.method_id;
            e_app_ff[cmd.idx]    <= req_ff.app_id;
            e_serial_ff[cmd.idx] <= (req_ff.kind == KIND_PANG) ? 32'd0 : req_ff.serial;
            e_stamp_ff[cmd.idx]  <= now_ff;
         end
         OP_MARK: asleep_stamp_ff[e_app_ff[cmd.idx]] <= e_stamp_ff[cmd.idx];
         default: ;
      endcase
   end

endmodule

// File: rtl/core/hbt_control.sv
// Controller: sequences table walks and emits result beats.
module hbt_control
   import hbt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  req_type req_data,
   input  sts_type sts,
   input  rsp_type res_ev,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCAN, S_PONG, S_PANG, S_FIN, S_REMOVE,
      S_WAKE, S_EMIT, S_FLUSH
   } state_type;

   state_type        state_ff, ret_ff;
   kind_type         kind_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] sh_ff;      // removal shift position
   logic [CNT_W-1:0] hi_ff;      // removal shift upper bound
   logic [RES_W-1:0] nres_ff;
   logic             pend_ff;    // staging register holds a beat
   rsp_type          hold_ff;
   logic             rv_ff;
   rsp_type          rd_ff;
   logic             fin_ff;

   logic             out_free;
   logic             can_push;
   logic             push;
   logic             seal;
   logic             move;
   rsp_type          push_beat;
   logic [IDX_W-1:0] idx;
   logic [CNT_W-1:0] idx_dn;

   assign out_free  = !rv_ff || rsp_ready;
   assign can_push  = !pend_ff || out_free;
   // A staged beat leaves once its last flag is final or a newer beat replaces it.
   assign move      = pend_ff && out_free && (hold_ff.last || push);
   assign req_ready = (state_ff == S_IDLE) && !pend_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   assign idx    = idx_ff[IDX_W-1:0];
   assign idx_dn = idx_ff - CNT_W'(1);

   // Command decode and staging control.
   always_comb begin
      cmd = '{op: OP_NONE, idx: idx, start_timer: 1'b0};
      push = 1'b0;
      seal = 1'b0;
      push_beat = res_ev;
      unique case (state_ff)
         S_IDLE:  if (req_valid && req_ready) cmd.op = OP_LOAD;
         S_SCAN:
            if (idx_ff < sts.count && nres_ff < RES_W'(MAX_RES) && sts.old_awake
                && can_push) begin
               cmd.op = OP_MARK;
               push = 1'b1;
               push_beat.last = 1'b0;
            end
         S_FLUSH: seal = pend_ff;
         S_DISPATCH:
            if (kind_ff == KIND_PING) begin
               cmd.start_timer = 1'b1;
               if (sts.count < CNT_W'(ENTRIES)) begin
                  cmd.op  = OP_APPEND;
                  cmd.idx = sts.count[IDX_W-1:0];
               end
            end
         S_PANG:
            if (idx_ff < sts.count) begin
               if (sts.match_pang) cmd.op = OP_SET_STAMP;
            end else begin
               cmd.start_timer = 1'b1;
               if (sts.count < CNT_W'(ENTRIES)) begin
                  cmd.op  = OP_APPEND;
                  cmd.idx = sts.count[IDX_W-1:0];
               end
            end
         S_FIN: cmd.idx = idx_dn[IDX_W-1:0];
         S_REMOVE: begin
            cmd.idx = sh_ff[IDX_W-1:0];
            if (sh_ff + CNT_W'(1) < hi_ff) cmd.op = OP_SHIFT;
            else cmd.op = OP_DEC;
         end
         S_WAKE:
            if (sts.count == '0 && !fin_ff && kind_ff == KIND_PONG) begin
               cmd.op = OP_STOP;
            end else if (can_push && sts.req_asleep) begin
               cmd.op = OP_WAKE;
               push = 1'b1;
               push_beat.last = 1'b1;
            end
         S_EMIT:
            // pang hit wakes; full table reports a drop
            if (can_push) begin
               if (fin_ff) begin
                  if (sts.req_asleep) begin
                     cmd.op = OP_WAKE;
                     push = 1'b1;
                     push_beat.last = 1'b1;
                  end
               end else begin
                  push = 1'b1;
                  push_beat.last = 1'b1;
               end
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         kind_ff  <= KIND_TICK;
         idx_ff   <= '0;
         sh_ff    <= '0;
         hi_ff    <= '0;
         nres_ff  <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         // Advance the staged beat into the output register.
         if (out_free) rv_ff <= move;
         if (move) rd_ff <= hold_ff;
         // Load a new beat into staging, or mark the held one last.
         if (push) pend_ff <= 1'b1;
         else if (move) pend_ff <= 1'b0;
         if (push) hold_ff <= push_beat;
         else if (seal) hold_ff.last <= 1'b1;
         unique case (state_ff)
            S_IDLE:
               if (req_valid && req_ready) begin
                  kind_ff <= kind_type'(req_data.kind);
                  idx_ff  <= '0;
                  nres_ff <= '0;
                  fin_ff  <= 1'b0;
                  state_ff <= S_DISPATCH;
               end
            S_DISPATCH:
               priority if (kind_ff == KIND_TICK)
                  state_ff <= sts.scan_due ? S_SCAN : S_IDLE;
               else if (kind_ff == KIND_PING) begin
                  if (sts.count < CNT_W'(ENTRIES)) state_ff <= S_IDLE;
                  else state_ff <= S_EMIT;
               end
               else if (kind_ff == KIND_PONG)   state_ff <= S_PONG;
               else if (kind_ff == KIND_PANG)   state_ff <= S_PANG;
               else if (kind_ff == KIND_FINISH) begin
                  idx_ff   <= sts.count;
                  state_ff <= S_FIN;
               end
               else state_ff <= S_IDLE;
            S_SCAN:
               if (idx_ff >= sts.count || nres_ff >= RES_W'(MAX_RES)) begin
                  state_ff <= S_FLUSH;
               end else if (!sts.old_awake) begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end else if (can_push) begin
                  nres_ff <= nres_ff + RES_W'(1);
                  idx_ff  <= idx_ff + CNT_W'(1);
               end
            S_FLUSH: state_ff <= S_IDLE;
            S_PONG:
               if (idx_ff >= sts.count) state_ff <= S_IDLE;
               else if (sts.match_pong) begin
                  sh_ff    <= idx_ff;
                  hi_ff    <= sts.count;
                  ret_ff   <= S_WAKE;
                  state_ff <= S_REMOVE;
               end else idx_ff <= idx_ff + CNT_W'(1);
            S_PANG:
               if (idx_ff >= sts.count) begin
                  state_ff <= (sts.count < CNT_W'(ENTRIES)) ? S_IDLE : S_EMIT;
               end else if (sts.match_pang) begin
                  fin_ff   <= 1'b1;
                  state_ff <= S_EMIT;
               end else idx_ff <= idx_ff + CNT_W'(1);
            S_FIN:
               // Walk down; remove an entry of the finished application.
               if (idx_ff == '0) state_ff <= S_IDLE;
               else begin
                  idx_ff <= idx_dn;
                  if (sts.app_match) begin
                     sh_ff    <= idx_dn;
                     hi_ff    <= sts.count;
                     ret_ff   <= S_FIN;
                     state_ff <= S_REMOVE;
                  end
               end
            S_REMOVE:
               if (sh_ff + CNT_W'(1) < hi_ff) sh_ff <= sh_ff + CNT_W'(1);
               else state_ff <= ret_ff;
            S_WAKE:
               if (sts.count == '0 && !fin_ff && kind_ff == KIND_PONG) fin_ff <= 1'b1;
               else if (can_push) state_ff <= S_IDLE;
            S_EMIT:
               if (can_push) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/heartbeat_timeout_table.sv
// Top level: heartbeat watchdog table with valid/ready channels and a CSR write port.
// One item at a time: the next is taken once the previous one is done and its last
// result beat has left the staging register. A due tick scans the entries and
// reports old ones of awake apps; a ping to a full table reports a drop; a pong walks
// to its match one entry per cycle and shifts the tail one entry per cycle; a pang
// walks the table and may report; a finish walks down the table and shifts the tail
// above each removed entry. Results leave through an output register with one staging
// beat behind it; a stalled result side holds a scan for each further report until a
// register frees up.
module heartbeat_timeout_table
   import hbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   cmd_type cmd;
   sts_type sts;
   rsp_type res_ev;

   hbt_datapath u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_data, .cmd, .sts, .res_ev
   );

   hbt_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_data, .req_data, .sts, .res_ev, .cmd
   );

endmodule

// File: verif/heartbeat_timeout_table_checker.sv
// Checker: watches both channels, predicts the watchdog reports and compares them.
`timescale 1ns / 100ps

module heartbeat_timeout_table_checker
   import hbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output int          mismatches,
   output int          reports_pending
);

   // predicted watchdog state
   logic [15:0] timeout_ms, scan_period_ms;
   logic [15:0] slot_method [ENTRIES];
   logic [3:0]  slot_app    [ENTRIES];
   logic [31:0] slot_serial [ENTRIES];
   logic [31:0] slot_stamp  [ENTRIES];
   int          slot_count;
   logic        app_asleep  [APPS];
   logic [31:0] app_slept_at[APPS];
   logic [31:0] now_ms;
   logic        timer_on;
   logic [15:0] timer_phase;

   rsp_type expected_reports[$];
   rsp_type item_reports[$];

   task automatic report(logic [1:0] ev, logic [15:0] m, logic [3:0] a, logic [31:0] el);
      rsp_type r;
      r.event_res = ev;
      r.method_id_out = m;
      r.app_id_out = a;
      r.elapsed_ms = el;
      r.last = 1'b0;
      item_reports.push_back(r);
   endtask

   task automatic arm_timer();
      if (!timer_on) begin
         timer_on = 1'b1;
         timer_phase = '0;
      end
   endtask

   task automatic drop_slot(int i);
      for (int k = i; k + 1 < slot_count; k++) begin
         slot_method[k] = slot_method[k+1];
         slot_app[k]    = slot_app[k+1];
         slot_serial[k] = slot_serial[k+1];
         slot_stamp[k]  = slot_stamp[k+1];
      end
      slot_count--;
   endtask

   task automatic add_slot(logic [15:0] m, logic [3:0] a, logic [31:0] s);
      if (slot_count < ENTRIES) begin
         slot_method[slot_count] = m;
         slot_app[slot_count]    = a;
         slot_serial[slot_count] = s;
         slot_stamp[slot_count]  = now_ms;
         slot_count++;
      end else begin
         report(EV_DROPPED, m, a, 32'd0);
      end
      arm_timer();
   endtask

   task automatic wake_app(logic [15:0] m, logic [3:0] a);
      if (app_asleep[a]) begin
         app_asleep[a] = 1'b0;
         report(EV_ACTIVE, m, a, now_ms - app_slept_at[a]);
      end
   endtask

   // Work out every report one request beat causes and queue them.
   task automatic predict_reports(req_type q);
      logic [15:0] period;
      logic [31:0] age;
      bit          hit;
      item_reports.delete();
      case (q.kind)
         KIND_TICK: begin
            now_ms++;
            if (timer_on) begin
               period = (scan_period_ms == 0) ? 16'd1 : scan_period_ms;
               timer_phase++;
               if (timer_phase >= period) begin
                  timer_phase = '0;
                  for (int i = 0; i < slot_count && item_reports.size() < MAX_RES; i++) begin
                     age = now_ms - slot_stamp[i];
                     if (age > {16'd0, timeout_ms} && !app_asleep[slot_app[i]]) begin
                        app_asleep[slot_app[i]] = 1'b1;
                        app_slept_at[slot_app[i]] = slot_stamp[i];
                        report(EV_INACTIVE, slot_method[i], slot_app[i], age);
                     end
                  end
               end
            end
         end
         KIND_PING: add_slot(q.method_id, q.app_id, q.serial);
         KIND_PONG: begin
            for (int i = 0; i < slot_count; i++) begin
               if (slot_method[i] == q.method_id && slot_app[i] == q.app_id &&
                   slot_serial[i] == q.serial) begin
                  drop_slot(i);
                  if (slot_count == 0) timer_on = 1'b0;
                  wake_app(q.method_id, q.app_id);
                  break;
               end
            end
         end
         KIND_PANG: begin
            hit = 0;
            for (int i = 0; i < slot_count; i++) begin
               if (slot_method[i] == q.method_id && slot_app[i] == q.app_id &&
                   slot_serial[i] == 0) begin
                  slot_stamp[i] = now_ms;
                  wake_app(q.method_id, q.app_id);
                  hit = 1;
                  break;
               end
            end
            if (!hit) add_slot(q.method_id, q.app_id, 32'd0);
         end
         KIND_FINISH: begin
            for (int i = slot_count - 1; i >= 0; i--)
               if (slot_app[i] == q.app_id) drop_slot(i);
         end
         default: ;
      endcase
      if (item_reports.size() > 0) item_reports[item_reports.size()-1].last = 1'b1;
      foreach (item_reports[i]) expected_reports.push_back(item_reports[i]);
   endtask

   // Predict on request beats, compare on result beats, track register writes.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         timeout_ms = TIMEOUT_RESET;
         scan_period_ms = PERIOD_RESET;
         slot_count = 0;
         foreach (app_asleep[i]) app_asleep[i] = 1'b0;
         now_ms = '0;
         timer_on = 1'b0;
         timer_phase = '0;
         expected_reports.delete();
         mismatches <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_TIMEOUT) timeout_ms = csr_data;
            else scan_period_ms = csr_data;
         end
         if (req_valid && req_ready) predict_reports(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_reports.pop_front();
               if (want.event_res != rsp_data.event_res ||
                   want.method_id_out != rsp_data.method_id_out ||
                   want.app_id_out != rsp_data.app_id_out ||
                   want.elapsed_ms != rsp_data.elapsed_ms ||
                   want.last != rsp_data.last) begin
                  $display("%0t: result mismatch expected %p actual %p", $time, want, rsp_data);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
      reports_pending <= expected_reports.size();
   end

endmodule

// File: verif/heartbeat_timeout_table_test.sv
// Testbench top: drives requests and register writes, stalls results, gives the verdict.
`timescale 1ns / 100ps

module heartbeat_timeout_table_test
   import hbt_pkg::*;
();

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_TIMEOUT;
   logic [15:0] csr_data = '0;
   int          mismatches, reports_pending;
   int          send_idle_pct = 0, recv_stall_pct = 0;
   int          quiet_cycles = 0;

   // pings still believed outstanding, used to aim pongs at real entries
   logic [15:0] open_method[$];
   logic [3:0]  open_app[$];
   logic [31:0] open_serial[$];

   heartbeat_timeout_table dut (.*);

   heartbeat_timeout_table_checker checker_i (.*);

   always #10 clock = ~clock;

   // randomly stall the result side
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("heartbeat_timeout_table_test: FAIL");
         $finish;
      end
   end

   task automatic send(logic [2:0] k, logic [15:0] m, logic [3:0] a, logic [31:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: k, method_id: m, app_id: a, serial: s};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (k == KIND_PING) begin
         open_method.push_back(m);
         open_app.push_back(a);
         open_serial.push_back(s);
      end
   endtask

   // drain everything, let the block go idle, then write both registers
   task automatic set_phase(logic [15:0] tmo, logic [15:0] per, int idle_pct, int stall_pct);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (reports_pending == 0);
      repeat (SETTLE) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_data <= tmo;
      @(posedge clock);
      csr_index <= CSR_PERIOD;
      csr_data <= per;
      @(posedge clock);
      csr_write <= 1'b0;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic random_items(int count, int app_span);
      int pick, j;
      logic [3:0] a;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         a = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(app_span));
         if (pick < 45) begin
            send(KIND_TICK, 16'($urandom), 4'($urandom), $urandom);
         end else if (pick < 65) begin
            send(KIND_PING, 16'($urandom_range(3)), a, $urandom_range(7));
         end else if (pick < 80) begin
            if (open_method.size() > 0 && $urandom_range(3) != 0) begin
               j = $urandom_range(open_method.size() - 1);
               send(KIND_PONG, open_method[j], open_app[j], open_serial[j]);
               open_method.delete(j);
               open_app.delete(j);
               open_serial.delete(j);
            end else begin
               send(KIND_PONG, 16'($urandom), a, $urandom);
            end
         end else if (pick < 92) begin
            send(KIND_PANG, 16'($urandom_range(3)), a, $urandom);
         end else if (pick < 97) begin
            send(KIND_FINISH, 16'($urandom), a, $urandom);
         end else begin
            send(3'($urandom_range(7, 5)), 16'($urandom), a, $urandom);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill the table, overflow it, then time everything out at once
      set_phase(16'd3, 16'd1, 0, 0);
      for (int i = 0; i < ENTRIES; i++)
         send(KIND_PING, (i == 0) ? 16'h0000 : 16'hFFFF, 4'(i),
              (i == 1) ? 32'hFFFF_FFFF : 32'(i));
      send(KIND_PING, 16'h1234, 4'd3, 32'd99);
      send(KIND_PANG, 16'h5555, 4'd7, 32'd0);
      repeat (5) send(KIND_TICK, 16'd0, 4'd0, 32'd0);
      send(KIND_PONG, 16'hFFFF, 4'd1, 32'hFFFF_FFFF);
      send(KIND_PONG, 16'hFFFF, 4'd1, 32'hFFFF_FFFF);
      send(KIND_FINISH, 16'd0, 4'd15, 32'd0);
      send(KIND_PANG, 16'hAAAA, 4'd15, 32'hDEAD_BEEF);
      repeat (2) send(KIND_TICK, 16'd0, 4'd0, 32'd0);
      send(KIND_PANG, 16'hAAAA, 4'd15, 32'd0);
      send(KIND_TICK, 16'd0, 4'd0, 32'd0);
      send(3'd5, 16'd1, 4'd2, 32'd3);
      send(3'd7, 16'd1, 4'd2, 32'd3);
      for (int i = 0; i < ENTRIES; i++) send(KIND_FINISH, 16'd0, 4'(i), 32'd0);
      open_method.delete();
      open_app.delete();
      open_serial.delete();

      // random phases across settings and idling patterns
      set_phase(16'd5, 16'd1, 0, 0);
      random_items(50, 3);
      set_phase(16'd1, 16'd0, 48, 0);
      random_items(40, 15);
      set_phase(16'd12, 16'd3, 0, 48);
      random_items(50, 5);
      set_phase(16'd65535, 16'd65535, 29, 29);
      random_items(25, 7);
      set_phase(16'd2, 16'd2, 29, 29);
      random_items(45, 15);
      set_phase(16'd8, 16'd1, 0, 0);
      random_items(40, 2);

      // drain and give the verdict
      req_valid <= 1'b0;
      @(posedge clock);
      wait (reports_pending == 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && reports_pending == 0)
         $display("heartbeat_timeout_table_test: PASS");
      else
         $display("heartbeat_timeout_table_test: FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/hbt_pkg.sv
rtl/core/hbt_datapath.sv
rtl/core/hbt_control.sv
rtl/core/heartbeat_timeout_table.sv
verif/heartbeat_timeout_table_checker.sv
verif/heartbeat_timeout_table_test.sv
